// File: rtl/core/scs_pkg.sv
package scs_pkg;

  // Default widths, handed to the top level as parameter defaults
  localparam int SPEED_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int ANGLE_W  = 16;
  localparam int FUNC_W   = 3;
  localparam int SECTOR_W = 3;
  localparam int QUAD_W   = 2;
  localparam int GATE_W   = 6;

  // Electrical angle in 1/64 degree: 60 degrees per sector, 360 for a full turn
  localparam logic [ANGLE_W-1:0] SECTOR_SPAN = ANGLE_W'(3840);
  localparam logic [ANGLE_W-1:0] FULL_TURN   = ANGLE_W'(23040);

  typedef enum logic [QUAD_W-1:0] {
    QUAD_FWD_POWER = 2'd0,
    QUAD_FWD_REGEN = 2'd1,
    QUAD_REV_POWER = 2'd2,
    QUAD_REV_REGEN = 2'd3
  } quad_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_COMMUTATE = 3'd0,
    FUNC_ALL_OFF   = 3'd1,
    FUNC_LOW_ON    = 3'd2,
    FUNC_HIGH_ON   = 3'd3,
    FUNC_ALL_ON    = 3'd4
  } func_t;

  // Gate patterns: bit0 UH, bit1 VH, bit2 WH, bit3 UL, bit4 VL, bit5 WL
  localparam logic [GATE_W-1:0] GATES_NONE    = 6'h00;
  localparam logic [GATE_W-1:0] GATES_LOW_ON  = 6'h38;
  localparam logic [GATE_W-1:0] GATES_HIGH_ON = 6'h07;
  localparam logic [GATE_W-1:0] GATES_ALL_ON  = 6'h3F;

  // Phase indexes
  localparam logic [1:0] PHASE_U = 2'd0;
  localparam logic [1:0] PHASE_V = 2'd1;
  localparam logic [1:0] PHASE_W = 2'd2;

  // Sector from angle, for angles below a full turn
  function automatic logic [SECTOR_W-1:0] sector_of_angle(input logic [ANGLE_W-1:0] angle);
    logic [SECTOR_W-1:0] base;
    begin
      if (angle >= ANGLE_W'(5 * 3840)) begin
        base = 3'd5;
      end else if (angle >= ANGLE_W'(4 * 3840)) begin
        base = 3'd4;
      end else if (angle >= ANGLE_W'(3 * 3840)) begin
        base = 3'd3;
      end else if (angle >= ANGLE_W'(2 * 3840)) begin
        base = 3'd2;
      end else if (angle >= SECTOR_SPAN) begin
        base = 3'd1;
      end else begin
        base = 3'd0;
      end
      return base;
    end
  endfunction

  // Shift three sectors round the turn
  function automatic logic [SECTOR_W-1:0] sector_opposite(input logic [SECTOR_W-1:0] s);
    logic [SECTOR_W-1:0] r;
    begin
      case (s)
        3'd0:    r = 3'd3;
        3'd1:    r = 3'd4;
        3'd2:    r = 3'd5;
        3'd3:    r = 3'd0;
        3'd4:    r = 3'd1;
        3'd5:    r = 3'd2;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // Gate pattern of each commutation stage
  function automatic logic [GATE_W-1:0] gates_of_stage(input logic [SECTOR_W-1:0] s);
    logic [GATE_W-1:0] g;
    begin
      case (s)
        3'd0:    g = 6'h11;
        3'd1:    g = 6'h21;
        3'd2:    g = 6'h22;
        3'd3:    g = 6'h0A;
        3'd4:    g = 6'h0C;
        3'd5:    g = 6'h14;
        default: g = 6'h11;
      endcase
      return g;
    end
  endfunction

  // High-side phase driven in each stage
  function automatic logic [1:0] phase_of_stage(input logic [SECTOR_W-1:0] s);
    logic [1:0] p;
    begin
      case (s)
        3'd0, 3'd1: p = PHASE_U;
        3'd2, 3'd3: p = PHASE_V;
        3'd4, 3'd5: p = PHASE_W;
        default:    p = PHASE_U;
      endcase
      return p;
    end
  endfunction

endpackage

// File: rtl/core/scs_if.sv
interface scs_item_if #(
  parameter int SPEED_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
);
  import scs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SPEED_WIDTH-1:0] speed;
  logic [SPEED_WIDTH-1:0] target_speed;
  logic [ANGLE_W-1:0]     angle;
  logic [COUNT_WIDTH-1:0] duty_count;
  logic [FUNC_W-1:0]      func;

  modport source (output valid, speed, target_speed, angle, duty_count, func, input ready);
  modport sink   (input valid, speed, target_speed, angle, duty_count, func, output ready);
endinterface

interface scs_result_if #(
  parameter int COUNT_WIDTH = 16
);
  import scs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [QUAD_W-1:0]      quadrant;
  logic [SECTOR_W-1:0]    sector;
  logic [GATE_W-1:0]      gate_enables;
  logic [COUNT_WIDTH-1:0] compare_u;
  logic [COUNT_WIDTH-1:0] compare_v;
  logic [COUNT_WIDTH-1:0] compare_w;

  modport source (output valid, quadrant, sector, gate_enables, compare_u, compare_v,
                  compare_w, input ready);
  modport sink   (input valid, quadrant, sector, gate_enables, compare_u, compare_v,
                  compare_w, output ready);
endinterface

interface scs_cfg_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/six_step_commutation_selector.sv
// Six-step commutation selector for one BLDC motor; a second motor takes a
// second instance.
// Channels: item (sink) carries one control tick: speed, target_speed,
// angle, duty_count and func. result (source) returns one word per tick:
// quadrant, held sector, the six gate enables and three high-side compares.
// cfg (sink) writes off_count; it is always ready and should be written only
// while no tick is in flight.
// An accepted tick is loaded into the input register, then moves into the
// result register when the result side can advance. Throughput: one tick per
// cycle while result.ready is held high; the quadrant, sector and gate logic
// between the two registers is a single shallow pass.
// A stalled receiver holds the result register; the input register still
// takes one more word, after which item.ready falls until result moves.
// Reset clears both stages, sets the held sector to stage zero, the held
// compares to zero and off_count to all ones.
module six_step_commutation_selector #(
  parameter int SPEED_WIDTH = scs_pkg::SPEED_WIDTH_DEF,
  parameter int COUNT_WIDTH = scs_pkg::COUNT_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  scs_item_if.sink     item,
  scs_result_if.source result,
  scs_cfg_if.sink      cfg
);
  import scs_pkg::*;

  // Input stage
  logic                   s1_valid;
  logic [SPEED_WIDTH-1:0] s1_speed;
  logic [SPEED_WIDTH-1:0] s1_target;
  logic [ANGLE_W-1:0]     s1_angle;
  logic [COUNT_WIDTH-1:0] s1_duty;
  logic [FUNC_W-1:0]      s1_func;

  // Result stage; sector and compares double as the held state
  logic                   out_valid;
  logic [QUAD_W-1:0]      quadrant;
  logic [SECTOR_W-1:0]    sector;
  logic [GATE_W-1:0]      gates;
  logic [COUNT_WIDTH-1:0] cmp_u;
  logic [COUNT_WIDTH-1:0] cmp_v;
  logic [COUNT_WIDTH-1:0] cmp_w;

  logic [COUNT_WIDTH-1:0] off_count;

  // Pass logic
  logic                   out_adv;
  logic                   s1_move;
  logic [SPEED_WIDTH:0]   err;
  logic                   spd_neg;
  logic                   err_neg;
  logic                   err_zero;
  quad_t                  quadrant_next;
  logic [SECTOR_W-1:0]    base;
  logic [SECTOR_W-1:0]    sector_next;
  logic [1:0]             phase;
  logic [GATE_W-1:0]      gates_next;
  logic [COUNT_WIDTH-1:0] cmp_u_next;
  logic [COUNT_WIDTH-1:0] cmp_v_next;
  logic [COUNT_WIDTH-1:0] cmp_w_next;

  // Handshakes
  assign out_adv    = !out_valid || result.ready;
  assign s1_move    = s1_valid && out_adv;
  assign item.ready = !s1_valid || out_adv;
  assign cfg.ready  = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      off_count <= '1;
    end else if (cfg.valid) begin
      off_count <= cfg.data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_speed  <= item.speed;
      s1_target <= item.target_speed;
      s1_angle  <= item.angle;
      s1_duty   <= item.duty_count;
      s1_func   <= item.func;
    end
  end

  // Classify the quadrant from the speed sign and the exact speed error
  always_comb begin
    err      = {s1_target[SPEED_WIDTH-1], s1_target} - {s1_speed[SPEED_WIDTH-1], s1_speed};
    spd_neg  = s1_speed[SPEED_WIDTH-1];
    err_neg  = err[SPEED_WIDTH];
    err_zero = (err == '0);
    if (!spd_neg) begin
      quadrant_next = err_neg ? QUAD_FWD_REGEN : QUAD_FWD_POWER;
    end else begin
      quadrant_next = (err_neg || err_zero) ? QUAD_REV_POWER : QUAD_REV_REGEN;
    end
  end

  // Advance the sector, or keep it for an angle at or past a full turn
  always_comb begin
    base = sector_of_angle(s1_angle);
    if (s1_angle >= FULL_TURN) begin
      sector_next = sector;
    end else if (quadrant_next == QUAD_FWD_REGEN || quadrant_next == QUAD_REV_POWER) begin
      sector_next = sector_opposite(base);
    end else begin
      sector_next = base;
    end
  end

  // Select gates and compares for the mode
  always_comb begin
    phase      = phase_of_stage(sector_next);
    gates_next = GATES_NONE;
    cmp_u_next = off_count;
    cmp_v_next = off_count;
    cmp_w_next = off_count;
    case (s1_func)
      FUNC_COMMUTATE: begin
        gates_next = gates_of_stage(sector_next);
        if (phase == PHASE_U) cmp_u_next = s1_duty;
        if (phase == PHASE_V) cmp_v_next = s1_duty;
        if (phase == PHASE_W) cmp_w_next = s1_duty;
      end
      FUNC_LOW_ON: begin
        gates_next = GATES_LOW_ON;
      end
      FUNC_HIGH_ON: begin
        gates_next = GATES_HIGH_ON;
        cmp_u_next = s1_duty;
        cmp_v_next = s1_duty;
        cmp_w_next = s1_duty;
      end
      FUNC_ALL_ON: begin
        gates_next = GATES_ALL_ON;
        cmp_u_next = cmp_u;
        cmp_v_next = cmp_v;
        cmp_w_next = cmp_w;
      end
      default: begin
        gates_next = GATES_NONE;
      end
    endcase
  end

  // Result register and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sector    <= '0;
      cmp_u     <= '0;
      cmp_v     <= '0;
      cmp_w     <= '0;
    end else begin
      if (out_adv) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        sector <= sector_next;
        cmp_u  <= cmp_u_next;
        cmp_v  <= cmp_v_next;
        cmp_w  <= cmp_w_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      quadrant <= quadrant_next;
      gates    <= gates_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.quadrant     = quadrant;
  assign result.sector       = sector;
  assign result.gate_enables = gates;
  assign result.compare_u    = cmp_u;
  assign result.compare_v    = cmp_v;
  assign result.compare_w    = cmp_w;

  // Held sector stays a legal stage
  a_sector_legal: assert property (@(posedge clk) disable iff (rst)
    sector < SECTOR_W'(6))
    else $error("held sector out of range");

  // A word in the input stage is never dropped while the result side stalls
  a_s1_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid)
    else $error("input stage word lost under stall");

  // All-on mode keeps the held compares
  a_all_on_holds: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_func == FUNC_ALL_ON |=> $stable(cmp_u) && $stable(cmp_v) && $stable(cmp_w))
    else $error("compares changed in all-on mode");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule
